// ----- hw/rtl/ngp_pkg.sv -----
package ngp_pkg;

  // Fixed field widths
  localparam int SLOT_W      = 12;
  localparam int LON_W       = 32;
  localparam int LAT_W       = 31;
  localparam int CCOUNT_W    = 7;
  localparam int GPC_W       = 13;
  localparam int RADIUS_W    = 23;
  localparam int DIST_W      = 25;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 23;

  // Angle scaling: inputs are radians * 2^ANGLE_FRAC_BITS, datapath is Q30
  localparam int ANGLE_FRAC_BITS = 29;
  localparam int HALF_SH         = 29 - ANGLE_FRAC_BITS;
  localparam int FULL_SH         = 30 - ANGLE_FRAC_BITS;

  // Datapath widths
  localparam int ANG_W  = 35;   // reduction and CORDIC angle
  localparam int XY_W   = 34;   // CORDIC vector, sines and cosines
  localparam int MUL_W  = 35;   // shared multiplier operand
  localparam int PROD_W = 2 * MUL_W;
  localparam int CANG_W = 34;   // central angle, Q30
  localparam int SQV_W  = 61;   // radicand h << 30
  localparam int SQR_W  = 31;   // root, at most 2^30

  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = 5;

  localparam logic signed [ANG_W-1:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [XY_W-1:0]  INV_GAIN    = 34'sd652032874;
  localparam logic [SQR_W-1:0]        Q30_ONE     = 31'd1073741824;
  localparam logic [DIST_W-1:0]       DIST_MAX    = 25'h1FFFFFF;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6378137;
  localparam logic [GPC_W-1:0]    GPC_RESET    = 13'd4096;

  typedef enum logic [1:0] {
    OP_LOAD_POINT = 2'd0,
    OP_LOAD_CAND  = 2'd1,
    OP_QUERY_ALL  = 2'd2,
    OP_QUERY_CAND = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS     = 1'd0,
    CFG_GRID_COUNT = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic step;
    logic rot;    // 1: rotation (drive z to 0), 0: vectoring (drive y to 0)
  } cor_ctl_t;

  function automatic logic [30:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [30:0] v;
    unique case (i)
      5'd0:  v = 31'd843314856;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043836;
      5'd3:  v = 31'd133525158;
      5'd4:  v = 31'd67021686;
      5'd5:  v = 31'd33543515;
      5'd6:  v = 31'd16775850;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194282;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048575;
      5'd11: v = 31'd524287;
      5'd12: v = 31'd262143;
      5'd13: v = 31'd131071;
      5'd14: v = 31'd65535;
      5'd15: v = 31'd32767;
      5'd16: v = 31'd16383;
      5'd17: v = 31'd8191;
      5'd18: v = 31'd4095;
      5'd19: v = 31'd2047;
      5'd20: v = 31'd1023;
      5'd21: v = 31'd511;
      5'd22: v = 31'd255;
      5'd23: v = 31'd127;
      5'd24: v = 31'd63;
      5'd25: v = 31'd31;
      5'd26: v = 31'd15;
      5'd27: v = 31'd7;
      5'd28: v = 31'd3;
      5'd29: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/nearest_grid_point_great_circle.sv -----
// Nearest grid point by great-circle (haversine) distance.
//
// Items arrive on start_i with operation_i and the payload ports; an item is
// taken at a clock edge where start_i is high and busy_o is low. Loads (point
// or candidate slot) are written in the accepting cycle and return nothing;
// busy_o stays low. A query of nonzero length raises busy_o and scans all grid
// points or the first candidate_count candidate slots, one point at a time.
// Per point the shared CORDIC runs four sine/cosine rotations (each a setup
// step, range reduction by whole multiples of pi, 30 steps and a store), the
// shared multiplier forms h, a bit-serial square root takes the roots of h
// and 1 - h, and the single CORDIC unit then runs 30 vectoring steps. A
// candidate entry that names a point past the table is skipped.
// The answer shows on nearest_index_o / distance_m_o for one cycle with
// result_valid_o high; the receiver cannot stall, and the next item may be
// accepted in that same cycle. A scan that finds no point gives no result.
// Config writes (cfg_valid_i/cfg_ready_o, ready always high) are meant for
// idle time. Reset returns to idle with radius and point count at defaults;
// table contents are undefined until loaded, so there is no clearing pass.
module nearest_grid_point_great_circle #(
  parameter int MAX_POINTS     = 4096,
  parameter int MAX_CANDIDATES = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [1:0]                            operation_i,
  input  logic [ngp_pkg::SLOT_W-1:0]            entry_slot_i,
  input  logic [ngp_pkg::SLOT_W-1:0]            candidate_point_i,
  input  logic signed [ngp_pkg::LON_W-1:0]      longitude_i,
  input  logic signed [ngp_pkg::LAT_W-1:0]      latitude_i,
  input  logic [ngp_pkg::CCOUNT_W-1:0]          candidate_count_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ngp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ngp_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic                                  result_valid_o,
  output logic [ngp_pkg::SLOT_W-1:0]            nearest_index_o,
  output logic [ngp_pkg::DIST_W-1:0]            distance_m_o
);
  import ngp_pkg::*;

  localparam int PIDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CIDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CNT_W  = ($clog2(MAX_POINTS + 1) > GPC_W) ? $clog2(MAX_POINTS + 1) : GPC_W;
  localparam logic [CNT_W-1:0] NPTS  = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] NCAND = CNT_W'(MAX_CANDIDATES);
  localparam int PT_W = LON_W + LAT_W;

  typedef enum logic [14:0] {
    ST_IDLE   = 15'h0001,
    ST_CREAD  = 15'h0002,
    ST_CCHK   = 15'h0004,
    ST_PREAD  = 15'h0008,
    ST_PLOAD  = 15'h0010,
    ST_SETUP  = 15'h0020,
    ST_RED    = 15'h0040,
    ST_ROT    = 15'h0080,
    ST_JOBEND = 15'h0100,
    ST_MUL    = 15'h0200,
    ST_SQRT   = 15'h0400,
    ST_VEC    = 15'h0800,
    ST_CMP    = 15'h1000,
    ST_DIST   = 15'h2000,
    ST_SPARE  = 15'h4000
  } state_e;

  state_e state_d, state_q;

  // config
  logic [RADIUS_W-1:0] radius_q;
  logic [GPC_W-1:0]    gpc_q;

  // scan control
  logic [CNT_W-1:0] k_q, n_q, idx_q, k_inc, n_new, slot_ext, cand_ext;
  logic             cand_q, found_q, adv_found;
  state_e           adv_state;

  // operands and intermediates
  logic signed [LON_W-1:0] qlon_q, plon_q;
  logic signed [LAT_W-1:0] qlat_q, plat_q;
  logic signed [ANG_W-1:0] red_q, theta;
  logic                    odd_q, red_ok;
  logic [1:0]              job_q, mstep_q;
  logic                    mph_q;
  logic signed [XY_W-1:0]  slon_q, slat_q, c1_q, c2_q;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-31:0] prod_sh;
  logic signed [PROD_W-29:0] hsum;
  logic [SQR_W-1:0]        h_clamp, h_q, a_q;
  logic [SQV_W-1:0]        sv_q, sbit_q;
  logic [SQV_W:0]          sr_q, sq_sum, sr_next;
  logic                    sq_ge, sqsel_q;
  logic [STEP_W-1:0]       scnt_q;
  logic [CANG_W-1:0]       best_c_q, c_new;
  logic [SLOT_W-1:0]       best_idx_q;
  logic [PROD_W-1:0]       rnd;
  logic [PROD_W-31:0]      dsh;

  // outputs
  logic                res_valid_q;
  logic [SLOT_W-1:0]   res_idx_q;
  logic [DIST_W-1:0]   res_dist_q;

  // CORDIC
  cor_ctl_t                cor_ctl;
  logic signed [XY_W-1:0]  cor_x0, cor_y0, cor_x, cor_y;
  logic signed [ANG_W-1:0] cor_z0, cor_z;
  logic                    cor_last;

  // memories
  logic              accept, is_query, pt_we, cand_we;
  logic [PT_W-1:0]   pt_rdata;
  logic [SLOT_W-1:0] cand_rdata;
  op_e               op;

  assign op       = op_e'(operation_i);
  assign accept   = start_i && (state_q == ST_IDLE);
  assign is_query = (op == OP_QUERY_ALL) || (op == OP_QUERY_CAND);
  assign slot_ext = CNT_W'(entry_slot_i);
  assign cand_ext = CNT_W'(cand_rdata);
  assign pt_we    = accept && (op == OP_LOAD_POINT) && (slot_ext < NPTS);
  assign cand_we  = accept && (op == OP_LOAD_CAND) && (slot_ext < NCAND);

  ngp_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (slot_ext[PIDX_W-1:0]),
    .wdata_i ({latitude_i, longitude_i}),
    .raddr_i (idx_q[PIDX_W-1:0]),
    .rdata_o (pt_rdata)
  );

  ngp_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_CANDIDATES)) u_cand_ram (
    .clk_i   (clk_i),
    .we_i    (cand_we),
    .waddr_i (slot_ext[CIDX_W-1:0]),
    .wdata_i (candidate_point_i),
    .raddr_i (k_q[CIDX_W-1:0]),
    .rdata_o (cand_rdata)
  );

  ngp_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cor_ctl),
    .x0_i   (cor_x0),
    .y0_i   (cor_y0),
    .z0_i   (cor_z0),
    .x_o    (cor_x),
    .y_o    (cor_y),
    .z_o    (cor_z),
    .last_o (cor_last)
  );

  // scan length, saturated to the table sizes
  always_comb begin
    if (op == OP_QUERY_ALL) begin
      n_new = (CNT_W'(gpc_q) > NPTS) ? NPTS : CNT_W'(gpc_q);
    end else begin
      n_new = (CNT_W'(candidate_count_i) > NCAND) ? NCAND : CNT_W'(candidate_count_i);
    end
  end

  // angle for the current sine/cosine job, Q30
  always_comb begin
    unique case (job_q)
      2'd0: theta = (ANG_W'(qlon_q) - ANG_W'(plon_q)) <<< HALF_SH;
      2'd1: theta = (ANG_W'(qlat_q) - ANG_W'(plat_q)) <<< HALF_SH;
      2'd2: theta = ANG_W'(plat_q) <<< FULL_SH;
      default: theta = ANG_W'(qlat_q) <<< FULL_SH;
    endcase
  end

  assign red_ok = !red_q[ANG_W-1] && (red_q < Q30_PI);

  // shared multiplier operands
  always_comb begin
    if (state_q == ST_DIST) begin
      mul_a = signed'(MUL_W'(radius_q));
      mul_b = signed'(MUL_W'(best_c_q));
    end else begin
      unique case (mstep_q)
        2'd0: begin mul_a = MUL_W'(slat_q); mul_b = MUL_W'(slat_q); end
        2'd1: begin mul_a = MUL_W'(c1_q);   mul_b = MUL_W'(c2_q);   end
        2'd2: begin mul_a = MUL_W'(slon_q); mul_b = MUL_W'(slon_q); end
        default: begin mul_a = MUL_W'(c1_q); mul_b = MUL_W'(slon_q); end
      endcase
    end
  end

  assign prod_sh = prod_q[PROD_W-1:30];
  assign hsum    = (PROD_W-28)'(slat_q) + (PROD_W-28)'(prod_sh);

  always_comb begin
    if (hsum[PROD_W-29]) begin
      h_clamp = '0;
    end else if (hsum > (PROD_W-28)'(Q30_ONE)) begin
      h_clamp = Q30_ONE;
    end else begin
      h_clamp = hsum[SQR_W-1:0];
    end
  end

  // one digit of the square root
  assign sq_sum  = sr_q + (SQV_W+1)'(sbit_q);
  assign sq_ge   = (SQV_W+1)'(sv_q) >= sq_sum;
  assign sr_next = sq_ge ? ((sr_q >> 1) + (SQV_W+1)'(sbit_q)) : (sr_q >> 1);

  assign c_new = cor_z[ANG_W-1] ? '0 : {cor_z[CANG_W-2:0], 1'b0};

  assign rnd = prod_q + (PROD_W'(1) << 29);
  assign dsh = rnd[PROD_W-1:30];

  // CORDIC start values
  always_comb begin
    if (state_q == ST_RED) begin
      cor_x0 = INV_GAIN;
      cor_y0 = '0;
      cor_z0 = red_q - Q30_HALF_PI;
    end else begin
      cor_x0 = XY_W'(sr_next);
      cor_y0 = XY_W'(a_q);
      cor_z0 = '0;
    end
  end

  // next entry of the scan
  always_comb begin
    k_inc     = k_q + CNT_W'(1);
    adv_found = found_q || (state_q == ST_CMP);
    if (k_inc == n_q) begin
      adv_state = adv_found ? ST_DIST : ST_IDLE;
    end else begin
      adv_state = cand_q ? ST_CREAD : ST_PREAD;
    end
  end

  always_comb begin
    state_d = state_q;
    cor_ctl = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_query && (n_new != '0)) begin
          state_d = (op == OP_QUERY_CAND) ? ST_CREAD : ST_PREAD;
        end
      end
      ST_CREAD:  state_d = ST_CCHK;
      ST_CCHK:   state_d = (cand_ext < NPTS) ? ST_PREAD : adv_state;
      ST_PREAD:  state_d = ST_PLOAD;
      ST_PLOAD:  state_d = ST_SETUP;
      ST_SETUP:  state_d = ST_RED;
      ST_RED: begin
        if (red_ok) begin
          cor_ctl.load = 1'b1;
          cor_ctl.rot  = 1'b1;
          state_d      = ST_ROT;
        end
      end
      ST_ROT: begin
        cor_ctl.step = 1'b1;
        cor_ctl.rot  = 1'b1;
        if (cor_last) begin
          state_d = ST_JOBEND;
        end
      end
      ST_JOBEND: state_d = (job_q == 2'd3) ? ST_MUL : ST_SETUP;
      ST_MUL: begin
        if (mph_q && (mstep_q == 2'd3)) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if ((scnt_q == STEP_W'(CORDIC_STEPS)) && sqsel_q) begin
          cor_ctl.load = 1'b1;
          state_d      = ST_VEC;
        end
      end
      ST_VEC: begin
        cor_ctl.step = 1'b1;
        if (cor_last) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP:  state_d = adv_state;
      ST_DIST: begin
        if (mph_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= RADIUS_RESET;
      gpc_q       <= GPC_RESET;
      k_q         <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      cand_q      <= 1'b0;
      found_q     <= 1'b0;
      odd_q       <= 1'b0;
      job_q       <= '0;
      mstep_q     <= '0;
      mph_q       <= 1'b0;
      scnt_q      <= '0;
      sqsel_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_RADIUS:     radius_q <= cfg_data_i[RADIUS_W-1:0];
          CFG_GRID_COUNT: gpc_q    <= cfg_data_i[GPC_W-1:0];
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && is_query) begin
            k_q     <= '0;
            idx_q   <= '0;
            n_q     <= n_new;
            cand_q  <= (op == OP_QUERY_CAND);
            found_q <= 1'b0;
          end
        end
        ST_CCHK: begin
          if (cand_ext < NPTS) begin
            idx_q <= cand_ext;
          end else begin
            k_q   <= k_inc;
            idx_q <= k_inc;
          end
        end
        ST_PLOAD: job_q <= '0;
        ST_SETUP: odd_q <= 1'b0;
        ST_RED: begin
          if (!red_ok) begin
            odd_q <= !odd_q;
          end
        end
        ST_JOBEND: begin
          job_q   <= job_q + 2'd1;
          mstep_q <= '0;
        end
        ST_MUL: begin
          mph_q <= !mph_q;
          if (mph_q) begin
            mstep_q <= mstep_q + 2'd1;
            if (mstep_q == 2'd3) begin
              scnt_q  <= '0;
              sqsel_q <= 1'b0;
            end
          end
        end
        ST_SQRT: begin
          if (scnt_q == STEP_W'(CORDIC_STEPS)) begin
            scnt_q  <= '0;
            sqsel_q <= 1'b1;
          end else begin
            scnt_q <= scnt_q + STEP_W'(1);
          end
        end
        ST_CMP: begin
          found_q <= 1'b1;
          k_q     <= k_inc;
          idx_q   <= k_inc;
        end
        ST_DIST: begin
          mph_q <= !mph_q;
          if (mph_q) begin
            res_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_query) begin
          qlon_q <= longitude_i;
          qlat_q <= latitude_i;
        end
      end
      ST_PLOAD: begin
        plon_q <= pt_rdata[LON_W-1:0];
        plat_q <= pt_rdata[PT_W-1:LON_W];
      end
      ST_SETUP: red_q <= theta + Q30_HALF_PI;
      ST_RED: begin
        // fold by whole multiples of pi
        if (red_q[ANG_W-1]) begin
          red_q <= red_q + Q30_PI;
        end else if (!red_ok) begin
          red_q <= red_q - Q30_PI;
        end
      end
      ST_JOBEND: begin
        unique case (job_q)
          2'd0: slon_q <= odd_q ? -cor_y : cor_y;
          2'd1: slat_q <= odd_q ? -cor_y : cor_y;
          2'd2: c1_q   <= odd_q ? -cor_x : cor_x;
          default: c2_q <= odd_q ? -cor_x : cor_x;
        endcase
      end
      ST_MUL: begin
        if (!mph_q) begin
          prod_q <= mul_a * mul_b;
        end else begin
          unique case (mstep_q)
            2'd0: slat_q <= XY_W'(prod_sh);
            2'd1: c1_q   <= XY_W'(prod_sh);
            2'd2: slon_q <= XY_W'(prod_sh);
            default: begin
              h_q    <= h_clamp;
              sv_q   <= {h_clamp, 30'd0};
              sr_q   <= '0;
              sbit_q <= SQV_W'(1) << (SQV_W - 1);
            end
          endcase
        end
      end
      ST_SQRT: begin
        if (scnt_q == STEP_W'(CORDIC_STEPS) && !sqsel_q) begin
          a_q    <= sr_next[SQR_W-1:0];
          sv_q   <= {Q30_ONE - h_q, 30'd0};
          sr_q   <= '0;
          sbit_q <= SQV_W'(1) << (SQV_W - 1);
        end else begin
          if (sq_ge) begin
            sv_q <= sv_q - sq_sum[SQV_W-1:0];
          end
          sr_q   <= sr_next;
          sbit_q <= sbit_q >> 2;
        end
      end
      ST_CMP: begin
        if (!found_q || (c_new < best_c_q)) begin
          best_c_q   <= c_new;
          best_idx_q <= idx_q[SLOT_W-1:0];
        end
      end
      ST_DIST: begin
        if (!mph_q) begin
          prod_q <= mul_a * mul_b;
        end else begin
          res_idx_q  <= best_idx_q;
          res_dist_q <= (dsh > (PROD_W-30)'(DIST_MAX)) ? DIST_MAX : dsh[DIST_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign result_valid_o  = res_valid_q;
  assign nearest_index_o = res_idx_q;
  assign distance_m_o    = res_dist_q;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("result strobe longer than one cycle");

  a_cordic_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> (!cor_ctl.step && !cor_ctl.load))
    else $error("CORDIC active while idle");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_query && (n_new != '0)) |=> busy_o)
    else $error("query accepted but block not busy");

  a_h_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (h_q <= Q30_ONE))
    else $error("haversine term out of range");

  a_result_after_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ($past(state_q) == ST_DIST))
    else $error("result without distance step");
`endif

endmodule

// ----- hw/rtl/ngp_ram.sv -----
module ngp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hw/rtl/ngp_cordic.sv -----
module ngp_cordic (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ngp_pkg::cor_ctl_t                      ctl_i,
  input  logic signed [ngp_pkg::XY_W-1:0]        x0_i,
  input  logic signed [ngp_pkg::XY_W-1:0]        y0_i,
  input  logic signed [ngp_pkg::ANG_W-1:0]       z0_i,
  output logic signed [ngp_pkg::XY_W-1:0]        x_o,
  output logic signed [ngp_pkg::XY_W-1:0]        y_o,
  output logic signed [ngp_pkg::ANG_W-1:0]       z_o,
  output logic                                   last_o
);
  import ngp_pkg::*;

  logic signed [XY_W-1:0]  x_q, y_q, xs, ys;
  logic signed [ANG_W-1:0] z_q, at;
  logic [STEP_W-1:0]       i_q;
  logic                    pos;

  assign xs  = x_q >>> i_q;
  assign ys  = y_q >>> i_q;
  assign at  = signed'(ANG_W'(atan_q30(i_q)));
  // rotation turns toward z = 0, vectoring toward y = 0
  assign pos = ctl_i.rot ? !z_q[ANG_W-1] : y_q[XY_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
    end else if (ctl_i.load) begin
      i_q <= '0;
    end else if (ctl_i.step) begin
      i_q <= i_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      x_q <= x0_i;
      y_q <= y0_i;
      z_q <= z0_i;
    end else if (ctl_i.step) begin
      if (pos) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign last_o = (i_q == STEP_W'(CORDIC_STEPS - 1));

endmodule

// ----- tb/sv/ngp_checker.sv -----
module ngp_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_o,
  input  logic [1:0]                     operation_i,
  input  logic [ngp_pkg::SLOT_W-1:0]     entry_slot_i,
  input  logic [ngp_pkg::SLOT_W-1:0]     candidate_point_i,
  input  logic signed [ngp_pkg::LON_W-1:0] longitude_i,
  input  logic signed [ngp_pkg::LAT_W-1:0] latitude_i,
  input  logic [ngp_pkg::CCOUNT_W-1:0]   candidate_count_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o,
  input  logic [ngp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ngp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           result_valid_o,
  input  logic [ngp_pkg::SLOT_W-1:0]     nearest_index_o,
  input  logic [ngp_pkg::DIST_W-1:0]     distance_m_o,
  output int                             fail_count,
  output int                             pending,
  output int                             result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ngp_pkg::*;

  localparam int NPTS  = 4096;
  localparam int NCAND = 64;
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint HPI_Q30  = 64'sd1686629713;
  localparam longint GAIN_INV = 64'sd652032874;
  localparam longint ONE_Q30  = 64'sd1073741824;

  typedef struct {
    logic [SLOT_W-1:0] idx;
    logic [DIST_W-1:0] meters;
  } answer_t;

  const longint atan_tbl [30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 7, 3, 1};

  longint            lon_mem  [NPTS];
  longint            lat_mem  [NPTS];
  logic [SLOT_W-1:0] cand_mem [NCAND];
  logic [RADIUS_W-1:0] radius;
  logic [GPC_W-1:0]    grid_count;
  answer_t           answers [$];
  int                fails, nres;

  // rotation CORDIC with reduction by whole multiples of pi
  task automatic sin_cos(input longint theta, output longint s, output longint c);
    longint t, k, r, x, y, z, nx;
    t = theta + HPI_Q30;
    k = t / PI_Q30;
    r = t % PI_Q30;
    if (r < 0) begin
      r += PI_Q30;
      k--;
    end
    z = r - HPI_Q30;
    x = GAIN_INV;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_tbl[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_tbl[i];
      end
      x = nx;
    end
    if (k[0]) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endtask

  function automatic longint vec_angle(input longint yi, input longint xi);
    longint x, y, z, nx;
    x = xi;
    y = yi;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_tbl[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_tbl[i];
      end
      x = nx;
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // haversine central angle, Q30 radians
  task automatic arc_between(input longint plon, input longint plat,
                             input longint qlon, input longint qlat,
                             output longint ang);
    longint s_lon, s_lat, c1, c2, dummy, h, a, b;
    sin_cos(qlon - plon, s_lon, dummy);
    sin_cos(qlat - plat, s_lat, dummy);
    sin_cos(plat * 2, dummy, c1);
    sin_cos(qlat * 2, dummy, c2);
    h = ((s_lat * s_lat) >>> 30) + ((((c1 * c2) >>> 30) * ((s_lon * s_lon) >>> 30)) >>> 30);
    if (h < 0) h = 0;
    if (h > ONE_Q30) h = ONE_Q30;
    a = longint'(floor_root(64'(h) << 30));
    b = longint'(floor_root(64'(ONE_Q30 - h) << 30));
    ang = vec_angle(a, b) * 2;
  endtask

  task automatic predict_query(input op_e op, input int ccount, input longint qlon,
                               input longint qlat);
    int n, idx, best_idx;
    longint ang, best;
    bit found;
    logic [63:0] d;
    answer_t ans;
    found = 0;
    best = 0;
    best_idx = 0;
    if (op == OP_QUERY_ALL) n = (grid_count > NPTS) ? NPTS : int'(grid_count);
    else n = (ccount > NCAND) ? NCAND : ccount;
    for (int k = 0; k < n; k++) begin
      idx = (op == OP_QUERY_ALL) ? k : int'(cand_mem[k]);
      arc_between(lon_mem[idx], lat_mem[idx], qlon, qlat, ang);
      if (!found || ang < best) begin // earlier entry keeps a tie
        found = 1;
        best = ang;
        best_idx = idx;
      end
    end
    if (found) begin
      d = 64'(radius) * 64'(best) + (64'd1 << 29);
      d >>= 30;
      ans.idx    = SLOT_W'(best_idx);
      ans.meters = (d > 64'(DIST_MAX)) ? DIST_MAX : DIST_W'(d);
      answers.push_back(ans);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got;
    if (!rst_ni) begin
      radius     = RADIUS_RESET;
      grid_count = GPC_RESET;
      answers.delete();
      fails = 0;
      nres  = 0;
      fail_count   <= 0;
      pending      <= 0;
      result_count <= 0;
    end else begin
      if (result_valid_o) begin
        nres++;
        if (answers.size() == 0) begin
          $error("result with nothing expected: index %0d distance %0d",
                 nearest_index_o, distance_m_o);
          fails++;
        end else begin
          got = answers.pop_front();
          if (nearest_index_o !== got.idx) begin
            $error("nearest_index: expected %0d, actual %0d", got.idx, nearest_index_o);
            fails++;
          end
          if (distance_m_o !== got.meters) begin
            $error("distance_m: expected %0d, actual %0d", got.meters, distance_m_o);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_idx_e'(cfg_index_i) == CFG_RADIUS) radius = cfg_data_i[RADIUS_W-1:0];
        else grid_count = cfg_data_i[GPC_W-1:0];
      end
      if (start_i && !busy_o) begin
        case (op_e'(operation_i))
          OP_LOAD_POINT: begin
            lon_mem[entry_slot_i] = longint'(longitude_i);
            lat_mem[entry_slot_i] = longint'(latitude_i);
          end
          OP_LOAD_CAND: if (entry_slot_i < NCAND) cand_mem[entry_slot_i] = candidate_point_i;
          default: predict_query(op_e'(operation_i), int'(candidate_count_i),
                                 longint'(longitude_i), longint'(latitude_i));
        endcase
      end
      fail_count   <= fails;
      pending      <= answers.size();
      result_count <= nres;
    end
  end

endmodule

// ----- tb/sv/tb_nearest_grid_point_great_circle.sv -----
module tb_nearest_grid_point_great_circle;
  timeunit 1ns;
  timeprecision 1ps;
  import ngp_pkg::*;

  localparam int LON_MAX = 1686629713;
  localparam int LAT_MAX = 843314857;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int PREFIX = 8;   // points 0..PREFIX-1 are always loaded

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] operation_i = '0;
  logic [SLOT_W-1:0] entry_slot_i = '0;
  logic [SLOT_W-1:0] candidate_point_i = '0;
  logic signed [LON_W-1:0] longitude_i = '0;
  logic signed [LAT_W-1:0] latitude_i = '0;
  logic [CCOUNT_W-1:0] candidate_count_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [SLOT_W-1:0] nearest_index_o;
  logic [DIST_W-1:0] distance_m_o;

  int fail_count, pending, result_count;
  int gap_pct;            // chance in 100 that the sender idles before an item
  int cycles;
  int n_items, n_queries;
  int cur_grid_count;
  logic [SLOT_W-1:0] loaded_pts [$];   // points known to hold data

  nearest_grid_point_great_circle i_dut (.*);

  ngp_checker i_checker (.*);

  initial forever #10 clk_i = ~clk_i;

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // one item; start_i stays high if the next item follows without a gap
  task automatic send_item(input op_e op, input logic [SLOT_W-1:0] slot,
                           input logic [SLOT_W-1:0] cand, input logic signed [31:0] lon,
                           input logic signed [30:0] lat, input logic [6:0] cnt);
    if ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i           <= 1'b1;
    operation_i       <= op;
    entry_slot_i      <= slot;
    candidate_point_i <= cand;
    longitude_i       <= lon;
    latitude_i        <= lat;
    candidate_count_i <= cnt;
    do @(posedge clk_i); while (busy_o);
    n_items++;
    if (op == OP_LOAD_POINT) loaded_pts.push_back(slot);
    if (op inside {OP_QUERY_ALL, OP_QUERY_CAND}) n_queries++;
  endtask

  // wait until the block is idle and every answer is in
  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy_o);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_GRID_COUNT) cur_grid_count = int'(val[GPC_W-1:0]);
  endtask

  function automatic logic signed [31:0] rand_lon();
    if ($urandom_range(99) < 75) return $urandom_range(0, 2 * 32'(LON_MAX)) - LON_MAX;
    return $urandom();
  endfunction

  function automatic logic signed [30:0] rand_lat();
    logic signed [31:0] v;
    if ($urandom_range(99) < 75) v = $urandom_range(0, 2 * LAT_MAX) - LAT_MAX;
    else v = $urandom();
    return v[30:0];
  endfunction

  function automatic logic [SLOT_W-1:0] any_loaded();
    return loaded_pts[$urandom_range(0, loaded_pts.size() - 1)];
  endfunction

  task automatic random_item();
    int r;
    logic [6:0] cnt;
    logic [SLOT_W-1:0] slot;
    r = $urandom_range(99);
    if (r < 35) begin
      slot = ($urandom_range(1)) ? SLOT_W'($urandom_range(0, 15)) : SLOT_W'($urandom());
      send_item(OP_LOAD_POINT, slot, $urandom(), rand_lon(), rand_lat(), $urandom());
    end else if (r < 55) begin
      // slots past the candidate list are ignored, so their payload is free
      slot = SLOT_W'($urandom_range(0, 90));
      if ($urandom_range(99) < 3) slot = $urandom();
      send_item(OP_LOAD_CAND, slot, (slot < 64) ? any_loaded() : SLOT_W'($urandom()),
                $urandom(), $urandom(), $urandom());
    end else if (r < 80 || cur_grid_count > PREFIX) begin
      r = $urandom_range(99);
      if (r < 3) cnt = 0;
      else if (r < 5) cnt = $urandom_range(64, 127);
      else if (r < 85) cnt = $urandom_range(1, 4);
      else cnt = $urandom_range(5, 12);
      send_item(OP_QUERY_CAND, $urandom(), $urandom(), rand_lon(), rand_lat(), cnt);
    end else begin
      send_item(OP_QUERY_ALL, $urandom(), $urandom(), rand_lon(), rand_lat(), $urandom());
    end
  endtask

  initial begin
    n_items = 0;
    n_queries = 0;
    cur_grid_count = 4096;
    gap_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corner angles in the always-loaded prefix, plus the top slot
    send_item(OP_LOAD_POINT, 0, 0, 0, 0, 0);
    send_item(OP_LOAD_POINT, 1, 0, LON_MAX, LAT_MAX, 0);
    send_item(OP_LOAD_POINT, 2, 0, -LON_MAX, -LAT_MAX, 0);
    send_item(OP_LOAD_POINT, 3, 0, 32'sh7FFF_FFFF, 31'sh3FFF_FFFF, 0);
    send_item(OP_LOAD_POINT, 4, 0, 32'sh8000_0000, 31'sh4000_0000, 0);
    send_item(OP_LOAD_POINT, 5, 0, -LON_MAX, -LAT_MAX, 0);   // twin of point 2
    send_item(OP_LOAD_POINT, 6, 0, 12345678, -7654321, 0);
    send_item(OP_LOAD_POINT, 7, 0, -1, 1, 0);
    send_item(OP_LOAD_POINT, 4095, 12'hFFF, 843314856, 421657428, 7'h7F);
    // fill the whole candidate list from loaded points
    for (int s = 0; s < 64; s++) send_item(OP_LOAD_CAND, s, any_loaded(), 0, 0, 0);
    send_item(OP_LOAD_CAND, 0, 5, 0, 0, 0);
    send_item(OP_LOAD_CAND, 1, 2, 0, 0, 0);
    send_item(OP_LOAD_CAND, 64, 12'hABC, 0, 0, 0);          // ignored slot
    send_item(OP_LOAD_CAND, 4095, 12'hFFF, 0, 0, 0);        // ignored slot
    send_item(OP_QUERY_CAND, 0, 0, -LON_MAX, -LAT_MAX, 2);  // tie, slot 0 wins
    send_item(OP_QUERY_CAND, 0, 0, 0, 0, 0);                // empty scan
    send_item(OP_QUERY_CAND, 0, 0, LON_MAX, LAT_MAX, 1);
    send_item(OP_QUERY_CAND, 0, 0, 0, 0, 64);
    send_item(OP_QUERY_CAND, 0, 0, 32'sh8000_0000, 31'sh4000_0000, 127);  // saturates
    settle();

    write_reg(CFG_RADIUS, 23'd6300000);
    write_reg(CFG_GRID_COUNT, 23'd0);
    send_item(OP_QUERY_ALL, 0, 0, 0, 0, 0);                 // empty scan
    settle();
    write_reg(CFG_GRID_COUNT, 23'd1);
    send_item(OP_QUERY_ALL, 0, 0, LON_MAX, -LAT_MAX, 0);
    send_item(OP_QUERY_ALL, 0, 0, 32'sh7FFF_FFFF, 31'sh3FFF_FFFF, 0);
    settle();

    // phase A: light sender gaps
    write_reg(CFG_RADIUS, 23'd6400000);
    write_reg(CFG_GRID_COUNT, PREFIX);
    gap_pct = 23;
    repeat (400) random_item();
    settle();

    // phase B: heavy sender gaps, widest radius
    write_reg(CFG_RADIUS, 23'h7FFFFF);
    write_reg(CFG_GRID_COUNT, 23'd3);
    gap_pct = 85;
    repeat (400) random_item();
    settle();

    // phase C: no gaps; full-table count, so only candidate queries run
    write_reg(CFG_RADIUS, 23'd6378137);
    write_reg(CFG_GRID_COUNT, 23'd4096);
    gap_pct = 0;
    repeat (400) random_item();
    settle();
    repeat (300) @(posedge clk_i);

    $display("Covered %0d items (%0d queries), %0d answers, in %0d cycles",
             n_items, n_queries, result_count, cycles);
    $display("Settings swept: radius low/high/max/default, point count 0/1/3/8/4096");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ngp_pkg.sv
hw/rtl/ngp_ram.sv
hw/rtl/ngp_cordic.sv
hw/rtl/nearest_grid_point_great_circle.sv
tb/sv/ngp_checker.sv
tb/sv/tb_nearest_grid_point_great_circle.sv
